// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the checker rtl; every macro takes a label, the
// clock, the reset that disables it and the checked expressions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== design/fpcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_pkg
// Types, constants and the byte-wide crc-32 update of the package checker.
// ----------------------------------------------------------------------------
package fpcc_pkg;

   localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
   localparam logic [31:0] CRC_PRESET  = 32'hFFFFFFFF;
   localparam logic [31:0] CRC_XOROUT  = 32'hFFFFFFFF;
   localparam logic [31:0] MAGIC_RESET = 32'h46574152;
   localparam logic [31:0] COUNT_MAX   = 32'hFFFFFFFF;

   typedef enum logic [2:0] {
      ERR_OK        = 3'd0,
      ERR_SHORT     = 3'd1,
      ERR_MAGIC     = 3'd2,
      ERR_SIZE      = 3'd3,
      ERR_CRC       = 3'd4
   } err_code_type;

   // one word moving from the input register into the package state
   typedef struct packed {
      logic fire;
      logic last;
   } step_ctl_type;

   // package state after the current word has been folded in
   typedef struct packed {
      logic [31:0] count;
      logic [31:0] magic;
      logic [31:0] version;
      logic [31:0] size;
      logic [31:0] stored_crc;
      logic [31:0] crc;
   } pkg_state_type;

   // reflected crc-32, one byte, lsb first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_cur,
                                            input logic [7:0]  data);
      logic [31:0] c;
      c = crc_cur ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== design/fpcc_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc channel interfaces
// Valid/ready channels for package bytes, verdicts and the magic register.
// ----------------------------------------------------------------------------
interface fpcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface fpcc_rsp_if;
   logic        valid;
   logic        ready;
   logic        verdict_ok;
   logic [2:0]  error_code;
   logic [31:0] firmware_version;
   logic [31:0] computed_crc;

   modport source (output valid, output verdict_ok, output error_code,
                   output firmware_version, output computed_crc, input ready);
   modport sink   (input valid, input verdict_ok, input error_code,
                   input firmware_version, input computed_crc, output ready);
endinterface

interface fpcc_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] expected_magic;

   modport source (output valid, output expected_magic, input ready);
   modport sink   (input valid, input expected_magic, output ready);
endinterface
`default_nettype wire

// ===== design/firmware_package_crc_checker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// firmware_package_crc_checker_top
// Firmware package verifier: header capture, payload crc-32, one verdict.
// ----------------------------------------------------------------------------
// Package bytes enter on req_ch, one byte per word, with last_byte set on the
// final byte; the block accepts one byte every cycle while no final byte is
// held back, and the verdict for a package is loaded into the result register
// and shown on rsp_ch after its final byte has passed through the input
// register. The rate is set by the byte-wide crc update between those
// registers. A full result register holds back only a final byte; payload
// bytes keep flowing. The user must write the magic word on csr_ch only while
// no package is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module firmware_package_crc_checker_top
   import fpcc_pkg::*;
#(
   parameter int HEADER_BYTES = 372
) (
   input  wire logic   clock,
   input  wire logic   reset,
   fpcc_req_if.sink    req_ch,
   fpcc_rsp_if.source  rsp_ch,
   fpcc_csr_if.sink    csr_ch
);

   logic          s0_valid_ff, s0_valid_in;
   logic [7:0]    s0_byte_ff;
   logic          s0_last_ff;
   logic [31:0]   magic_ff, magic_in;
   logic          s0_go;
   logic          req_fire;
   logic          res_busy;
   step_ctl_type  step;
   pkg_state_type state_next;

   // a final word waits only while the result register is still occupied
   assign s0_go        = s0_valid_ff && !(s0_last_ff && res_busy);
   assign req_ch.ready = !s0_valid_ff || s0_go;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign step.fire = s0_go;
   assign step.last = s0_last_ff;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (req_fire) begin
         s0_valid_in = 1'b1;
      end else if (s0_go) begin
         s0_valid_in = 1'b0;
      end
      magic_in = magic_ff;
      if (csr_ch.valid) begin
         magic_in = csr_ch.expected_magic;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         magic_ff    <= MAGIC_RESET;
      end else begin
         s0_valid_ff <= s0_valid_in;
         magic_ff    <= magic_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_byte_ff <= req_ch.byte_value;
         s0_last_ff <= req_ch.last_byte;
      end
   end

   fpcc_parse #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_value (s0_byte_ff),
      .state_next (state_next)
   );

   fpcc_verdict #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_verdict (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .state_next     (state_next),
      .expected_magic (magic_ff),
      .res_busy       (res_busy),
      .rsp            (rsp_ch)
   );

   `ASSERT_NEXT(a_word_enters, clock, reset, req_fire, s0_valid_ff)
   `ASSERT_IMPLIES(a_payload_flows, clock, reset, s0_valid_ff && !s0_last_ff, req_ch.ready)
   `ASSERT_NEXT(a_csr_takes, clock, reset, csr_ch.valid, magic_ff == $past(csr_ch.expected_magic))

endmodule
`default_nettype wire

// ===== design/fpcc_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_parse
// Header field capture, payload crc and saturating byte count, one word a cycle while step.fire is set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpcc_parse
   import fpcc_pkg::*;
#(
   parameter int HEADER_BYTES = 372
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire step_ctl_type  step,
   input  wire logic [7:0]    byte_value,
   output pkg_state_type      state_next
);

   logic [31:0] count_ff, magic_ff, version_ff, size_ff, stored_crc_ff, crc_ff;
   logic [31:0] count_in, magic_in, version_in, size_in, stored_crc_in, crc_in;
   logic [4:0]  lane_base;
   logic [31:0] idx;

   assign idx       = count_ff;
   assign lane_base = {idx[1:0], 3'b000};

   // state with the current word folded in, before the end-of-package clear
   always_comb begin
      state_next.count      = (count_ff == COUNT_MAX) ? count_ff : count_ff + 32'd1;
      state_next.magic      = magic_ff;
      state_next.version    = version_ff;
      state_next.size       = size_ff;
      state_next.stored_crc = stored_crc_ff;
      state_next.crc        = crc_ff;
      priority if (idx < 32'd4) begin
         state_next.magic[lane_base +: 8] = magic_ff[lane_base +: 8] | byte_value;
      end else if (idx < 32'd8) begin
         state_next.version[lane_base +: 8] = version_ff[lane_base +: 8] | byte_value;
      end else if (idx >= 32'd12 && idx < 32'd16) begin
         state_next.size[lane_base +: 8] = size_ff[lane_base +: 8] | byte_value;
      end else if (idx >= 32'd16 && idx < 32'd20) begin
         state_next.stored_crc[lane_base +: 8] = stored_crc_ff[lane_base +: 8] | byte_value;
      end else begin
      end
      if (idx >= 32'(HEADER_BYTES)) begin
         state_next.crc = crc_byte(crc_ff, byte_value);
      end
   end

   always_comb begin
      count_in      = count_ff;
      magic_in      = magic_ff;
      version_in    = version_ff;
      size_in       = size_ff;
      stored_crc_in = stored_crc_ff;
      crc_in        = crc_ff;
      if (step.fire) begin
         if (step.last) begin
            count_in      = '0;
            magic_in      = '0;
            version_in    = '0;
            size_in       = '0;
            stored_crc_in = '0;
            crc_in        = CRC_PRESET;
         end else begin
            count_in      = state_next.count;
            magic_in      = state_next.magic;
            version_in    = state_next.version;
            size_in       = state_next.size;
            stored_crc_in = state_next.stored_crc;
            crc_in        = state_next.crc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         magic_ff      <= '0;
         version_ff    <= '0;
         size_ff       <= '0;
         stored_crc_ff <= '0;
         crc_ff        <= CRC_PRESET;
      end else begin
         count_ff      <= count_in;
         magic_ff      <= magic_in;
         version_ff    <= version_in;
         size_ff       <= size_in;
         stored_crc_ff <= stored_crc_in;
         crc_ff        <= crc_in;
      end
   end

   `ASSERT_NEXT(a_clear_count, clock, reset, step.fire && step.last, count_ff == 32'd0)
   `ASSERT_NEXT(a_clear_crc, clock, reset, step.fire && step.last, crc_ff == CRC_PRESET)
   `ASSERT_NEXT(a_count_moves, clock, reset, step.fire && !step.last, count_ff != 32'd0)

endmodule
`default_nettype wire

// ===== design/fpcc_verdict.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_verdict
// End-of-package checks in priority order and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpcc_verdict
   import fpcc_pkg::*;
#(
   parameter int HEADER_BYTES = 372
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire step_ctl_type  step,
   input  wire pkg_state_type state_next,
   input  wire logic [31:0]   expected_magic,
   output logic               res_busy,
   fpcc_rsp_if.source         rsp
);

   logic          rsp_valid_ff, rsp_valid_in;
   logic          ok_ff;
   err_code_type  code_ff, code_in;
   logic [31:0]   version_ff;
   logic [31:0]   crc_out_ff, crc_out_in;
   logic [32:0]   size_total;
   logic          load;

   assign load       = step.fire && step.last;
   assign crc_out_in = state_next.crc ^ CRC_XOROUT;
   // size plus header length, kept one bit wider so it never wraps
   assign size_total = {1'b0, state_next.size} + 33'(HEADER_BYTES);

   always_comb begin
      priority if (state_next.count < 32'(HEADER_BYTES)) begin
         code_in = ERR_SHORT;
      end else if (state_next.magic != expected_magic) begin
         code_in = ERR_MAGIC;
      end else if (size_total != {1'b0, state_next.count}) begin
         code_in = ERR_SIZE;
      end else if (crc_out_in != state_next.stored_crc) begin
         code_in = ERR_CRC;
      end else begin
         code_in = ERR_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff      <= (code_in == ERR_OK);
         code_ff    <= code_in;
         version_ff <= state_next.version;
         crc_out_ff <= crc_out_in;
      end
   end

   assign res_busy             = rsp_valid_ff && !rsp.ready;
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.verdict_ok       = ok_ff;
   assign rsp.error_code       = code_ff;
   assign rsp.firmware_version = version_ff;
   assign rsp.computed_crc     = crc_out_ff;

   `ASSERT_IMPLIES(a_ok_matches_code, clock, reset, rsp_valid_ff, ok_ff == (code_ff == ERR_OK))
   `ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_valid_ff)
   `ASSERT_NEVER(a_no_overwrite, clock, reset, load && res_busy)

endmodule
`default_nettype wire
